// ===== hdl/oaid_pkg.sv =====
// shared types and constants for the ordered list block
// holds request kind codes, controller command and datapath status structs
// no dependencies
package oaid_pkg;

    // fixed field widths
    localparam int unsigned POS_W   = 5;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned KIND_W  = 2;

    // capacity after reset
    localparam logic [COUNT_W-1:0] CAP_RESET = 5'd10;

    // request kind codes
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd3;

    // memory read address source
    typedef enum logic [2:0] {
        RD_NONE,
        RD_POS,
        RD_LAST,
        RD_PREV,
        RD_NEXT
    } rd_op_t;

    // memory write address and data source
    typedef enum logic [2:0] {
        WR_NONE,
        WR_WORD_AT_POS,
        WR_WORD_AT_COUNT,
        WR_SHIFT_UP,
        WR_SHIFT_DOWN
    } wr_op_t;

    // result word source
    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_ONES,
        OUT_HELD
    } out_sel_t;

    // fill count update
    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     req_load;
        rd_op_t   rd_op;
        wr_op_t   wr_op;
        logic     hold_load;
        logic     out_load;
        logic     out_ok;
        out_sel_t out_sel;
        cnt_op_t  cnt_op;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              room;
        logic              ins_ok;
        logic              idx_ok;
        logic              pos_is_count;
        logic              rd_at_pos;
        logic              next_in_range;
        logic              out_free;
    } dp_status_t;

endpackage

// ===== hdl/ordered_array_insert_delete.sv =====
// Ordered bounded list of signed words with append, insert, delete and get.
// Channels: s_ (request in), m_ (result out), cfg_ (capacity register write).
// One request gives exactly one result. A request is taken only while the
// block is idle; the result is held in an output register, so a stalled
// m_tready leaves the next request free to be taken and worked on until its
// own result needs that register.
// Append, refused requests and insert at the end of the list go from the
// decide step straight to the result; get first waits for the read of its
// entry; insert elsewhere moves every entry from the position up one place
// higher, and delete moves every later entry one place lower, through the
// entry memory, which moves one entry per cycle. The result is registered
// as the block returns to idle, ready to take the next request.
// Reset (aresetn low, synchronous) empties the list, sets capacity to 10 and
// drops any waiting result; the entry memory itself is not cleared.
// Capacity writes are always taken and should only be made while idle.
// Depends on oaid_pkg, oaid_ctrl and oaid_datapath.
module ordered_array_insert_delete #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned WORD_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // capacity register write
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [oaid_pkg::COUNT_W-1:0]          cfg_data,
    // request: tdata = position, word_in (from bit 0 up), zero padded
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((oaid_pkg::POS_W + WORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // request: tuser = kind
    input  logic [oaid_pkg::KIND_W-1:0]           s_tuser,
    // result: tdata = word_out, fill (from bit 0 up), zero padded
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((oaid_pkg::COUNT_W + WORD_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    // result: tuser = accepted
    output logic [0:0]                            m_tuser
);
    import oaid_pkg::*;

    localparam int unsigned M_TDATA_W = ((COUNT_W + WORD_WIDTH + 7) / 8) * 8;

    dp_cmd_t               cmd;
    dp_status_t            status;
    logic [WORD_WIDTH-1:0] m_word;
    logic                  m_ok;
    logic [COUNT_W-1:0]    m_fill;

    assign cfg_ready = 1'b1;

    oaid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    oaid_datapath #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_kind   (s_tuser),
        .s_pos    (s_tdata[POS_W-1:0]),
        .s_word   (s_tdata[POS_W +: WORD_WIDTH]),
        .cfg_wr   (cfg_valid),
        .cfg_data (cfg_data),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_word   (m_word),
        .m_ok     (m_ok),
        .m_fill   (m_fill)
    );

    // result packing
    assign m_tdata    = M_TDATA_W'({m_fill, m_word});
    assign m_tuser[0] = m_ok;

endmodule

// ===== hdl/oaid_datapath.sv =====
// datapath of the ordered list: entry memory, fill count, capacity register,
// request and result registers, address generation for the shift sequences
// depends on oaid_pkg
module oaid_datapath #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned WORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  oaid_pkg::dp_cmd_t             cmd,
    output oaid_pkg::dp_status_t          status,
    input  logic [oaid_pkg::KIND_W-1:0]   s_kind,
    input  logic [oaid_pkg::POS_W-1:0]    s_pos,
    input  logic [WORD_WIDTH-1:0]         s_word,
    input  logic                          cfg_wr,
    input  logic [oaid_pkg::COUNT_W-1:0]  cfg_data,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [WORD_WIDTH-1:0]         m_word,
    output logic                          m_ok,
    output logic [oaid_pkg::COUNT_W-1:0]  m_fill
);
    import oaid_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // entry store, undefined until written
    logic [WORD_WIDTH-1:0] mem [DEPTH];

    logic [COUNT_W-1:0]    cap_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [KIND_W-1:0]     kind_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [WORD_WIDTH-1:0] word_reg;
    logic [POS_W-1:0]      rd_addr_reg;
    logic [WORD_WIDTH-1:0] rd_data_reg;
    logic [WORD_WIDTH-1:0] held_reg;
    logic                  m_valid_reg;
    logic [WORD_WIDTH-1:0] m_word_reg;
    logic                  m_ok_reg;
    logic [COUNT_W-1:0]    m_fill_reg;

    logic [POS_W-1:0]      rd_addr;
    logic [POS_W-1:0]      wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic                  wr_en;
    logic [POS_W:0]        rd_addr_inc;
    logic [WORD_WIDTH-1:0] out_word;

    function automatic logic [AW-1:0] to_addr(input logic [POS_W-1:0] a);
        logic [AW+POS_W-1:0] wide;
        wide = {{AW{1'b0}}, a};
        return wide[AW-1:0];
    endfunction

    // request checks against fill count and capacity
    always_comb begin
        rd_addr_inc          = {1'b0, rd_addr_reg} + 6'd1;
        status.kind          = kind_reg;
        status.room          = (count_reg < cap_reg) && (32'(count_reg) < DEPTH);
        status.ins_ok        = status.room && (pos_reg <= count_reg);
        status.idx_ok        = pos_reg < count_reg;
        status.pos_is_count  = pos_reg == count_reg;
        status.rd_at_pos     = rd_addr_reg == pos_reg;
        status.next_in_range = rd_addr_inc < {1'b0, count_reg};
        status.out_free      = !m_valid_reg || m_ready;
    end

    // read address select
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = pos_reg;
        case (cmd.rd_op)
            RD_POS:  rd_addr = pos_reg;
            RD_LAST: rd_addr = count_reg - 5'd1;
            RD_PREV: rd_addr = rd_addr_reg - 5'd1;
            RD_NEXT: rd_addr = rd_addr_inc[POS_W-1:0];
            default: rd_en   = 1'b0;
        endcase
    end

    // write address and data select
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = pos_reg;
        wr_data = word_reg;
        case (cmd.wr_op)
            WR_WORD_AT_POS: begin
                wr_addr = pos_reg;
            end
            WR_WORD_AT_COUNT: begin
                wr_addr = count_reg;
            end
            WR_SHIFT_UP: begin
                wr_addr = rd_addr_inc[POS_W-1:0];
                wr_data = rd_data_reg;
            end
            WR_SHIFT_DOWN: begin
                wr_addr = rd_addr_reg - 5'd1;
                wr_data = rd_data_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // next fill count and result word
    always_comb begin
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + 5'd1;
            CNT_DEC: count_next = count_reg - 5'd1;
            default: count_next = count_reg;
        endcase
        case (cmd.out_sel)
            OUT_ONES: out_word = '1;
            OUT_HELD: out_word = held_reg;
            default:  out_word = '0;
        endcase
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[to_addr(wr_addr)] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[to_addr(rd_addr)];
            rd_addr_reg <= rd_addr;
        end
    end

    // request, held word and result registers
    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            kind_reg <= s_kind;
            pos_reg  <= s_pos;
            word_reg <= s_word;
        end
        if (cmd.hold_load) begin
            held_reg <= rd_data_reg;
        end
        if (cmd.out_load) begin
            m_word_reg <= out_word;
            m_ok_reg   <= cmd.out_ok;
            m_fill_reg <= count_next;
        end
    end

    // control state: capacity, fill count, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                cap_reg <= cfg_data;
            end
            if (cmd.out_load) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;
    assign m_ok    = m_ok_reg;
    assign m_fill  = m_fill_reg;

`ifndef SYNTHESIS
    // a waiting result reports the current fill count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_fill_reg == count_reg))
        else $error("result fill differs from list length");

    // reads only touch live entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (rd_addr < count_reg))
        else $error("read beyond list length");

    // writes stay inside the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (32'(wr_addr) < DEPTH))
        else $error("write beyond store depth");
`endif

endmodule

// ===== hdl/oaid_ctrl.sv =====
// controller of the ordered list: sequences decide, shift and result steps
// drives datapath commands from datapath status
// depends on oaid_pkg
module oaid_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  oaid_pkg::dp_status_t status,
    output oaid_pkg::dp_cmd_t    cmd
);
    import oaid_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_INS_SHIFT,
        ST_INS_WRITE,
        ST_GET_WAIT,
        ST_DEL_WAIT,
        ST_DEL_SHIFT,
        ST_FINISH
    } state_t;

    state_t   state_reg, state_next;
    logic     fin_ok_reg, fin_ok_next;
    out_sel_t fin_sel_reg, fin_sel_next;
    cnt_op_t  fin_cnt_reg, fin_cnt_next;

    // next state and commands
    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        fin_ok_next  = fin_ok_reg;
        fin_sel_next = fin_sel_reg;
        fin_cnt_next = fin_cnt_reg;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.req_load = s_valid;
                if (s_valid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                fin_ok_next  = 1'b0;
                fin_sel_next = OUT_ZERO;
                fin_cnt_next = CNT_KEEP;
                state_next   = ST_FINISH;
                case (status.kind)
                    KIND_APPEND: begin
                        if (status.room) begin
                            cmd.wr_op    = WR_WORD_AT_COUNT;
                            fin_ok_next  = 1'b1;
                            fin_cnt_next = CNT_INC;
                        end
                    end
                    KIND_INSERT: begin
                        if (status.ins_ok) begin
                            fin_ok_next  = 1'b1;
                            fin_cnt_next = CNT_INC;
                            if (status.pos_is_count) begin
                                cmd.wr_op = WR_WORD_AT_POS;
                            end else begin
                                cmd.rd_op  = RD_LAST;
                                state_next = ST_INS_SHIFT;
                            end
                        end
                    end
                    KIND_DELETE: begin
                        if (status.idx_ok) begin
                            cmd.rd_op    = RD_POS;
                            fin_ok_next  = 1'b1;
                            fin_sel_next = OUT_HELD;
                            fin_cnt_next = CNT_DEC;
                            state_next   = ST_DEL_WAIT;
                        end
                    end
                    KIND_GET: begin
                        if (status.idx_ok) begin
                            cmd.rd_op    = RD_POS;
                            fin_ok_next  = 1'b1;
                            fin_sel_next = OUT_HELD;
                            state_next   = ST_GET_WAIT;
                        end else begin
                            fin_sel_next = OUT_ONES;
                        end
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            // move one entry up per cycle, from the end down to the position
            ST_INS_SHIFT: begin
                cmd.wr_op = WR_SHIFT_UP;
                if (status.rd_at_pos) begin
                    state_next = ST_INS_WRITE;
                end else begin
                    cmd.rd_op = RD_PREV;
                end
            end
            ST_INS_WRITE: begin
                cmd.wr_op  = WR_WORD_AT_POS;
                state_next = ST_FINISH;
            end
            ST_GET_WAIT: begin
                cmd.hold_load = 1'b1;
                state_next    = ST_FINISH;
            end
            // keep the removed word, then start pulling later entries down
            ST_DEL_WAIT: begin
                cmd.hold_load = 1'b1;
                if (status.next_in_range) begin
                    cmd.rd_op  = RD_NEXT;
                    state_next = ST_DEL_SHIFT;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DEL_SHIFT: begin
                cmd.wr_op = WR_SHIFT_DOWN;
                if (status.next_in_range) begin
                    cmd.rd_op = RD_NEXT;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            // hand the result over once the output register is free
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_ok   = fin_ok_reg;
                    cmd.out_sel  = fin_sel_reg;
                    cmd.cnt_op   = fin_cnt_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and result summary registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fin_ok_reg  <= 1'b0;
            fin_sel_reg <= OUT_ZERO;
            fin_cnt_reg <= CNT_KEEP;
        end else begin
            state_reg   <= state_next;
            fin_ok_reg  <= fin_ok_next;
            fin_sel_reg <= fin_sel_next;
            fin_cnt_reg <= fin_cnt_next;
        end
    end

`ifndef SYNTHESIS
    // a result is only loaded into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a waiting result");

    // the list length only changes for a request that was carried out
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && fin_cnt_reg != CNT_KEEP) |-> fin_ok_reg)
        else $error("length change on refused request");

    // a taken request is decided in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DECIDE))
        else $error("taken request not decided");
`endif

endmodule
